[src/stb_pkg.sv]
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants for the soft timer bank
// Command codes, transfer payload structs, the timer entry layout kept in
// the state memory, and the controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

    // Default number of timers in the bank
    localparam int TIMER_COUNT_DEF = 8;

    // Widths fixed by the command and result formats
    localparam int KIND_W   = 3;
    localparam int INDEX_W  = 3;
    localparam int TICKS_W  = 32;
    localparam int MASK_W   = 8;

    // Largest bank size supported, and a width that can hold it
    localparam int TIMER_COUNT_MAX = 64;
    localparam int COUNT_W         = 7;

    // Command codes
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 3'd0,
        KIND_START   = 3'd1,
        KIND_RESTART = 3'd2,
        KIND_RESET   = 3'd3,
        KIND_QUERY   = 3'd4
    } stb_kind_t;

    // Command transfer
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] timer_index;
        logic [TICKS_W-1:0] period;
    } stb_in_t;

    // Result transfer
    typedef struct packed {
        logic              ended;
        logic [MASK_W-1:0] expired_mask;
    } stb_out_t;

    // One timer as held in the state memory
    typedef struct packed {
        logic               running;
        logic               finished;
        logic [TICKS_W-1:0] period_ticks;
        logic [TICKS_W-1:0] elapsed_ticks;
    } stb_entry_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_TICK,
        ST_DONE
    } stb_state_t;

endpackage : stb_pkg

`default_nettype wire

[src/soft_timer_bank.sv]
// ----------------------------------------------------------------------------
// soft_timer_bank: bank of one-shot tick timers
// Timer state sits in a single-port-read, single-port-write memory; each
// command reads, updates and writes back the entries it touches.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_ channel (s_valid/s_ready, payload s_data) and
//   each produces exactly one result on the m_ channel (m_valid/m_ready,
//   payload m_data). A tick advances every running timer and reports which
//   of timers 0 to MASK_W-1 are at or past their period in expired_mask;
//   start, restart, reset and query address one timer; query reports in ended.
//   A single-timer command reads its entry together with its transfer, then
//   modifies and writes the entry back, then loads the result register.
//   A tick walks the state memory one entry per cycle through its one read
//   port, then loads the result register. The next command is taken once
//   the result of the previous one has been moved into the output register,
//   so a tick holds off new commands until its walk is done.
//   A result waiting on m_ready does not block the next command; only a
//   second result waits in the controller until the output register frees.
//   Reset clears the controller and the per-entry valid flags;
//   an entry never written since reset reads as all zero, so no clearing
//   pass over the memory is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_timer_bank
    import stb_pkg::*;
#(
    parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire stb_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output stb_out_t     m_data
);

    localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int EXT_W = (IDX_W > 3) ? IDX_W : 3;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

    // State memory and its valid flags
    stb_entry_t             mem [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] valid_reg;
    stb_entry_t             rd_entry_reg;
    logic                   rd_valid_reg;

    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;
    stb_entry_t       wr_entry;

    // Controller registers
    stb_state_t       state_reg, state_next;
    logic [IDX_W-1:0] walk_reg, walk_next;
    stb_in_t          cmd_reg, cmd_next;
    logic             ok_reg, ok_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic             ended_reg, ended_next;
    logic             m_valid_reg, m_valid_next;
    stb_out_t         m_data_reg, m_data_next;

    logic in_ok;
    assign in_ok = (COUNT_W'(s_data.timer_index) < COUNT_W'(TIMER_COUNT));

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Synchronous read and write of the state memory
    always_ff @(posedge aclk) begin
        rd_entry_reg <= mem[rd_addr];
        if (mem_we) begin
            mem[wr_addr] <= wr_entry;
        end
    end

    // Track which entries hold written data; read data follows its flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (mem_we) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        walk_reg   <= walk_next;
        cmd_reg    <= cmd_next;
        ok_reg     <= ok_next;
        mask_reg   <= mask_next;
        ended_reg  <= ended_next;
        m_data_reg <= m_data_next;
    end

    // Next state, memory access and result
    always_comb begin
        stb_entry_t        cur;
        logic [TICKS_W-1:0] el_new;
        logic [EXT_W-1:0]  walk_ext;

        state_next   = state_reg;
        walk_next    = walk_reg;
        cmd_next     = cmd_reg;
        ok_next      = ok_reg;
        mask_next    = mask_reg;
        ended_next   = ended_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rd_addr      = walk_reg;
        mem_we       = 1'b0;
        wr_addr      = walk_reg;
        wr_entry     = '0;

        cur      = rd_valid_reg ? rd_entry_reg : '0;
        el_new   = (cur.elapsed_ticks == '1) ? cur.elapsed_ticks
                                              : cur.elapsed_ticks + TICKS_W'(1);
        walk_ext = EXT_W'(walk_reg);

        // Drop the output once it has been taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                // Issue the first read together with the command transfer
                if (s_valid) begin
                    cmd_next   = s_data;
                    ok_next    = in_ok;
                    mask_next  = '0;
                    ended_next = 1'b0;
                    walk_next  = '0;
                    if (s_data.kind == KIND_TICK) begin
                        rd_addr    = '0;
                        state_next = ST_TICK;
                    end else begin
                        rd_addr    = in_ok ? IDX_W'(s_data.timer_index) : '0;
                        state_next = ST_CMD;
                    end
                end
            end

            ST_CMD: begin
                // Modify the addressed entry and write back any change (none if out of range)
                wr_addr    = IDX_W'(cmd_reg.timer_index);
                wr_entry   = cur;
                state_next = ST_DONE;
                if (ok_reg) begin
                    unique case (cmd_reg.kind)
                        KIND_START: begin
                            mem_we                 = 1'b1;
                            wr_entry.running       = 1'b1;
                            wr_entry.finished      = 1'b0;
                            wr_entry.period_ticks  = cmd_reg.period;
                            wr_entry.elapsed_ticks = '0;
                        end
                        KIND_RESTART: begin
                            mem_we                 = 1'b1;
                            wr_entry.running       = 1'b1;
                            wr_entry.finished      = 1'b0;
                            wr_entry.elapsed_ticks = '0;
                        end
                        KIND_RESET: begin
                            mem_we   = 1'b1;
                            wr_entry = '0;
                        end
                        KIND_QUERY: begin
                            if (cur.finished && cur.running) begin
                                mem_we           = 1'b1;
                                wr_entry.running = 1'b0;
                                ended_next       = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_TICK: begin
                // Advance the entry whose data arrives; read the next one
                wr_addr  = walk_reg;
                wr_entry = cur;
                if (cur.running) begin
                    mem_we                 = 1'b1;
                    wr_entry.elapsed_ticks = el_new;
                    if (el_new >= cur.period_ticks) begin
                        wr_entry.finished = 1'b1;
                        if (COUNT_W'(walk_reg) < COUNT_W'(MASK_W)) begin
                            mask_next[walk_ext[2:0]] = 1'b1;
                        end
                    end
                end
                if (walk_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end else begin
                    walk_next = walk_reg + IDX_W'(1);
                    rd_addr   = walk_reg + IDX_W'(1);
                end
            end

            ST_DONE: begin
                // Hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.ended        = ended_reg;
                    m_data_next.expired_mask = mask_reg;
                    state_next               = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A single-timer command goes straight to its read-modify-write step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.kind != KIND_TICK) |=> (state_reg == ST_CMD))
        else $error("single-timer command did not enter the update step");

    // Memory writes only happen in the update steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CMD || state_reg == ST_TICK))
        else $error("state memory written outside an update step");

    // The tick walk stays inside the bank
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK) |-> (COUNT_W'(walk_reg) < COUNT_W'(TIMER_COUNT)))
        else $error("tick walk beyond the last timer");

    // A result never carries both a query answer and an expiry mask
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.ended && (m_data.expired_mask != '0)))
        else $error("result mixes query answer and expiry mask");

    // A result is only loaded from the done state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_DONE))
        else $error("result appeared outside the done state");

endmodule : soft_timer_bank

`default_nettype wire
